// ===== sv/icaf_pkg.sv =====
// icaf_pkg: constants, widths, register indexes and helper functions
// for the attitude filter; no dependencies
package icaf_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int CORDIC_STEPS   = 30;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 28;
	localparam int MUL_W          = 34;
	localparam int PROD_W         = 2 * MUL_W;
	localparam int DIV_W          = 48;
	localparam int DIG_W          = 16;
	localparam int DIV_DIGITS     = DIV_W / DIG_W;
	localparam int DREM_W         = 7;
	localparam int RATE_PRE_SH    = 2;
	localparam int STEP_PRE_SH    = 3;
	localparam int RATE_RECIP_SH  = 29;
	localparam int STEP_RECIP_SH  = 30;

	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_ROLL_OFF  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_PITCH_OFF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_X_OFF      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_Y_OFF      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_Z_OFF      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT     = 3'd5;

	localparam logic [16:0] WEIGHT_RESET = 17'd62915;
	localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
	localparam logic signed [MUL_W-1:0] RAD2DEG_Q24 = 34'sd961263669;
	localparam longint QUARTER_PI_Q30 = 64'sd843314857;

	// divide by 164 = 4 * 41 and by 1000 = 8 * 125, halves added first
	localparam logic [9:0]        RATE_HALF  = 10'd82;
	localparam logic [9:0]        STEP_HALF  = 10'd500;
	localparam logic [DREM_W-1:0] RATE_ODD   = 7'd41;
	localparam logic [DREM_W-1:0] STEP_ODD   = 7'd125;
	localparam logic [23:0]       RATE_RECIP = 24'd13094413;
	localparam logic [23:0]       STEP_RECIP = 24'd8589935;

	typedef logic signed [MUL_W-1:0] atan_tab_t [CORDIC_STEPS];

	// restoring division, elaboration only
	function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] r;
		logic [63:0] q;
		int b;
		r = '0;
		q = '0;
		for (b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// arctangent of 2^-i in Q30 radians, series summed in Q40
	function automatic atan_tab_t build_atan_tab();
		atan_tab_t t;
		longint s;
		longint term;
		int i;
		int k;
		int e;
		t[0] = MUL_W'(QUARTER_PI_Q30);
		for (i = 1; i < CORDIC_STEPS; i++) begin
			s = 0;
			for (k = 0; i * (2 * k + 1) <= 40; k++) begin
				e = 40 - i * (2 * k + 1);
				term = longint'(div_u64(64'(1) << e, 64'(2 * k + 1)));
				if (k % 2 == 1) s = s - term;
				else s = s + term;
			end
			t[i] = MUL_W'((s + 512) >>> 10);
		end
		return t;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan_tab();

	// shift right with rounding to nearest, halves away from zero
	function automatic logic signed [PROD_W-1:0] round_shift(
		input logic signed [PROD_W-1:0] n, input int unsigned sh);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] half;
		logic [PROD_W-1:0] r;
		mag  = n[PROD_W-1] ? PROD_W'(-n) : PROD_W'(n);
		half = PROD_W'(1) << (sh - 1);
		r    = (mag + half) >> sh;
		return n[PROD_W-1] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(32'sh7fffffff);
		lo = PROD_W'(32'sh80000000);
		if (v > hi) return 32'sh7fffffff;
		if (v < lo) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

// ===== sv/icaf_sample_if.sv =====
// icaf_sample_if: input channel, one raw imu sample per item
// no dependencies
interface icaf_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;
	logic        [15:0] elapsed_ms;

	modport source(output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		elapsed_ms, input ready);
	modport sink(input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		elapsed_ms, output ready);
endinterface

// ===== sv/icaf_result_if.sv =====
// icaf_result_if: output channel, filtered angles per item
// no dependencies
interface icaf_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] roll_angle;
	logic signed [31:0] pitch_angle;
	logic signed [31:0] yaw_angle;

	modport source(output valid, roll_angle, pitch_angle, yaw_angle, input ready);
	modport sink(input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

// ===== sv/imu_complementary_attitude_filter.sv =====
// imu_complementary_attitude_filter: roll/pitch/yaw complementary filter
// depends on icaf_pkg, icaf_sample_if, icaf_result_if
//
// One sample item yields one result item with the updated roll, pitch and yaw
// in 2^-FRAC_BITS degree. The work runs on one shared multiplier, a 2-bit-per-cycle
// square root and a 30-step cordic under one sequencer; the divisions by 164 and
// 1000 use the shared multiplier as a reciprocal multiply, one 16-bit digit a cycle.
// Per tilt axis run two squarings, square root, cordic and degree scaling (only the
// squarings with a zero numerator), per gyro axis a rate multiply, rate division,
// step multiply and step division plus two blend steps for roll and pitch, and one
// accept and one output state per item. The block takes no item while one is in
// work; a finished result waits in an output register while the next item is taken.
module imu_complementary_attitude_filter #(
	parameter int FRAC_BITS = icaf_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	icaf_sample_if.sink                     sample,
	icaf_result_if.source                   result,
	input  logic                            cfg_wr_en,
	input  logic [icaf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [icaf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import icaf_pkg::*;

	localparam int unsigned DEG_SH = 54 - FRAC_BITS;
	localparam logic signed [MUL_W-1:0] RATE_SCALE = MUL_W'(10) <<< FRAC_BITS;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQA  = 4'd1;
	localparam logic [3:0] ST_SQB  = 4'd2;
	localparam logic [3:0] ST_SQRT = 4'd3;
	localparam logic [3:0] ST_COR  = 4'd4;
	localparam logic [3:0] ST_DEG  = 4'd5;
	localparam logic [3:0] ST_RMUL = 4'd6;
	localparam logic [3:0] ST_RDIV = 4'd7;
	localparam logic [3:0] ST_SMUL = 4'd8;
	localparam logic [3:0] ST_SDIV = 4'd9;
	localparam logic [3:0] ST_BW   = 4'd10;
	localparam logic [3:0] ST_BA   = 4'd11;
	localparam logic [3:0] ST_DONE = 4'd12;

	logic [3:0] state_q;
	logic [1:0] axis_q;
	logic [5:0] cnt_q;

	logic signed [23:0] roll_off_q, pitch_off_q;
	logic signed [27:0] gx_off_q, gy_off_q, gz_off_q;
	logic        [16:0] weight_q;

	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic        [15:0] dt_q;

	logic signed [31:0] roll_q, pitch_q, yaw_q;
	logic signed [31:0] res_roll_q, res_pitch_q, res_yaw_q;
	logic               res_valid_q;

	logic signed [PROD_W-1:0] sq_q, bl_q;
	logic        [59:0]       sr_q;
	logic        [31:0]       rem_q;
	logic        [29:0]       root_q;
	logic signed [MUL_W-1:0]  x_q, y_q, z_q;
	logic signed [MUL_W-1:0]  acc_r_q, acc_p_q;
	logic        [DIV_W-1:0]  dq_q;
	logic        [DREM_W-1:0] drem_q;
	logic                     dneg_q;
	logic signed [MUL_W-1:0]  rate_q;
	logic signed [31:0]       prop_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [16:0]       num;
	logic signed [15:0]       tilt_a, graw;
	logic signed [MUL_W-1:0]  tilt_off, goff, acc_sel;
	logic signed [31:0]       est_sel;
	logic        [16:0]       w_eff;
	logic        [31:0]       rad;
	logic        [33:0]       r2, trial;
	logic                     sq_ge;
	logic        [29:0]       root_nx;
	logic                     sdiv;
	logic        [DREM_W+DIG_W-1:0] dv;
	logic        [DIG_W-1:0]  dig;
	logic        [DREM_W+DIG_W-1:0] dig_prod;
	logic        [DREM_W-1:0] drem_nx;
	logic        [DIV_W-1:0]  dq_nx;
	logic signed [PROD_W-1:0] quot_s, tilt_val, est_sum;
	logic        [PROD_W-1:0] prod_mag;
	logic                     res_load;

	assign w_eff = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
	assign num   = axis_q[0] ? -17'(ax_q) : 17'(ay_q);
	assign tilt_a = axis_q[0] ? ay_q : ax_q;
	assign tilt_off = axis_q[0] ? MUL_W'(pitch_off_q) : MUL_W'(roll_off_q);
	assign acc_sel = axis_q[0] ? acc_p_q : acc_r_q;

	always_comb begin
		case (axis_q)
			2'd0: begin
				graw    = gx_q;
				goff    = MUL_W'(gx_off_q);
				est_sel = roll_q;
			end
			2'd1: begin
				graw    = gy_q;
				goff    = MUL_W'(gy_off_q);
				est_sel = pitch_q;
			end
			default: begin
				graw    = gz_q;
				goff    = MUL_W'(gz_off_q);
				est_sel = yaw_q;
			end
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_SQA: begin
				mul_a = MUL_W'(tilt_a);
				mul_b = MUL_W'(tilt_a);
			end
			ST_SQB: begin
				mul_a = MUL_W'(az_q);
				mul_b = MUL_W'(az_q);
			end
			ST_DEG: begin
				mul_a = z_q;
				mul_b = RAD2DEG_Q24;
			end
			ST_RMUL: begin
				mul_a = MUL_W'(graw);
				mul_b = RATE_SCALE;
			end
			ST_RDIV: begin
				mul_a = MUL_W'(dv);
				mul_b = MUL_W'(RATE_RECIP);
			end
			ST_SMUL: begin
				mul_a = rate_q;
				mul_b = MUL_W'({1'b0, dt_q});
			end
			ST_SDIV: begin
				mul_a = MUL_W'(dv);
				mul_b = MUL_W'(STEP_RECIP);
			end
			ST_BW: begin
				mul_a = MUL_W'({1'b0, w_eff});
				mul_b = MUL_W'(prop_q);
			end
			ST_BA: begin
				mul_a = MUL_W'({1'b0, WEIGHT_ONE - w_eff});
				mul_b = acc_sel;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
	assign rad      = sq_q[31:0] + prod[31:0];

	// square root step
	assign r2      = {rem_q, sr_q[59:58]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign sq_ge   = r2 >= trial;
	assign root_nx = {root_q[28:0], sq_ge};

	// divider digit step, quotient digit by reciprocal multiply
	assign sdiv     = (state_q == ST_SDIV);
	assign dv       = {drem_q, dq_q[DIV_W-1 -: DIG_W]};
	assign dig      = sdiv ? prod[STEP_RECIP_SH +: DIG_W] : prod[RATE_RECIP_SH +: DIG_W];
	assign dig_prod = sdiv ? (DREM_W+DIG_W)'(dig) * (DREM_W+DIG_W)'(STEP_ODD)
		: (DREM_W+DIG_W)'(dig) * (DREM_W+DIG_W)'(RATE_ODD);
	assign drem_nx  = DREM_W'(dv - dig_prod);
	assign dq_nx    = {dq_q[DIV_W-DIG_W-1:0], dig};
	assign quot_s = dneg_q ? -PROD_W'({1'b0, dq_nx}) : PROD_W'({1'b0, dq_nx});

	assign tilt_val = round_shift(prod, DEG_SH);
	assign est_sum  = PROD_W'(est_sel) + quot_s;

	assign res_load = (state_q == ST_DONE) && (!res_valid_q || result.ready);

	assign sample.ready      = (state_q == ST_IDLE);
	assign result.valid      = res_valid_q;
	assign result.roll_angle  = res_roll_q;
	assign result.pitch_angle = res_pitch_q;
	assign result.yaw_angle   = res_yaw_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_off_q  <= '0;
			pitch_off_q <= '0;
			gx_off_q    <= '0;
			gy_off_q    <= '0;
			gz_off_q    <= '0;
			weight_q    <= WEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				REG_ACCEL_ROLL_OFF:  roll_off_q  <= cfg_wdata[23:0];
				REG_ACCEL_PITCH_OFF: pitch_off_q <= cfg_wdata[23:0];
				REG_GYRO_X_OFF:      gx_off_q    <= cfg_wdata;
				REG_GYRO_Y_OFF:      gy_off_q    <= cfg_wdata;
				REG_GYRO_Z_OFF:      gz_off_q    <= cfg_wdata;
				REG_GYRO_WEIGHT:     weight_q    <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			cnt_q       <= '0;
			roll_q      <= '0;
			pitch_q     <= '0;
			yaw_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						axis_q  <= 2'd0;
						state_q <= ST_SQA;
					end
				end
				ST_SQA: state_q <= ST_SQB;
				ST_SQB: begin
					if (num == '0) begin
						if (axis_q == 2'd0) begin
							axis_q  <= 2'd1;
							state_q <= ST_SQA;
						end else begin
							axis_q  <= 2'd0;
							state_q <= ST_RMUL;
						end
					end else begin
						cnt_q   <= 6'd29;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) state_q <= ST_COR;
					else cnt_q <= cnt_q - 6'd1;
				end
				ST_COR: begin
					if (cnt_q == 6'(CORDIC_STEPS - 1)) state_q <= ST_DEG;
					else cnt_q <= cnt_q + 6'd1;
				end
				ST_DEG: begin
					if (axis_q == 2'd0) begin
						axis_q  <= 2'd1;
						state_q <= ST_SQA;
					end else begin
						axis_q  <= 2'd0;
						state_q <= ST_RMUL;
					end
				end
				ST_RMUL: begin
					cnt_q   <= 6'(DIV_DIGITS - 1);
					state_q <= ST_RDIV;
				end
				ST_RDIV: begin
					if (cnt_q == '0) state_q <= ST_SMUL;
					else cnt_q <= cnt_q - 6'd1;
				end
				ST_SMUL: begin
					cnt_q   <= 6'(DIV_DIGITS - 1);
					state_q <= ST_SDIV;
				end
				ST_SDIV: begin
					if (cnt_q == '0) begin
						if (axis_q == 2'd2) begin
							yaw_q   <= sat32(est_sum);
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_BW;
						end
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_BW: state_q <= ST_BA;
				ST_BA: begin
					if (axis_q == 2'd0) roll_q <= sat32(round_shift(bl_q + prod, 16));
					else pitch_q <= sat32(round_shift(bl_q + prod, 16));
					axis_q  <= axis_q + 2'd1;
					state_q <= ST_RMUL;
				end
				ST_DONE: begin
					if (res_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ax_q <= sample.accel_x;
				ay_q <= sample.accel_y;
				az_q <= sample.accel_z;
				gx_q <= sample.gyro_x;
				gy_q <= sample.gyro_y;
				gz_q <= sample.gyro_z;
				dt_q <= (sample.elapsed_ms == '0) ? 16'd1 : sample.elapsed_ms;
			end
			ST_SQA: sq_q <= prod;
			ST_SQB: begin
				if (num == '0) begin
					if (axis_q == 2'd0) acc_r_q <= -tilt_off;
					else acc_p_q <= -tilt_off;
				end
				sr_q   <= {rad, 28'd0};
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				rem_q  <= sq_ge ? 32'(r2 - trial) : r2[31:0];
				root_q <= root_nx;
				sr_q   <= {sr_q[57:0], 2'b00};
				if (cnt_q == '0) begin
					x_q <= MUL_W'({1'b0, root_nx});
					y_q <= MUL_W'(num) <<< 14;
					z_q <= '0;
				end
			end
			ST_COR: begin
				if (!y_q[MUL_W-1]) begin
					x_q <= x_q + (y_q >>> cnt_q[4:0]);
					y_q <= y_q - (x_q >>> cnt_q[4:0]);
					z_q <= z_q + ATAN_TAB[cnt_q[4:0]];
				end else begin
					x_q <= x_q - (y_q >>> cnt_q[4:0]);
					y_q <= y_q + (x_q >>> cnt_q[4:0]);
					z_q <= z_q - ATAN_TAB[cnt_q[4:0]];
				end
			end
			ST_DEG: begin
				if (axis_q == 2'd0) acc_r_q <= MUL_W'(tilt_val) - tilt_off;
				else acc_p_q <= MUL_W'(tilt_val) - tilt_off;
			end
			ST_RMUL, ST_SMUL: begin
				dneg_q <= prod[PROD_W-1];
				dq_q   <= (state_q == ST_RMUL) ?
					DIV_W'((prod_mag + PROD_W'(RATE_HALF)) >> RATE_PRE_SH) :
					DIV_W'((prod_mag + PROD_W'(STEP_HALF)) >> STEP_PRE_SH);
				drem_q <= '0;
			end
			ST_RDIV: begin
				drem_q <= drem_nx;
				dq_q   <= dq_nx;
				if (cnt_q == '0) rate_q <= MUL_W'(quot_s) - goff;
			end
			ST_SDIV: begin
				drem_q <= drem_nx;
				dq_q   <= dq_nx;
				if (cnt_q == '0) prop_q <= sat32(est_sum);
			end
			ST_BW: bl_q <= prod;
			ST_DONE: begin
				if (res_load) begin
					res_roll_q  <= roll_q;
					res_pitch_q <= pitch_q;
					res_yaw_q   <= yaw_q;
				end
			end
			default: ;
		endcase
	end

endmodule
